// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL; only spfc_ser includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SPFC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define SPFC_ASSERT_RST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: reset assertion failed");
`else
`define SPFC_ASSERT(lbl, clk, rst_n, prop)
`define SPFC_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// File: hw/rtl/spfc_pkg.sv
// Types, constants and byte/CRC helpers for the sensor packet framer.
package spfc_pkg;

	localparam int unsigned InWidth     = 104;
	localparam int unsigned PktLen      = 12;
	localparam int unsigned CrcSpan     = 11;
	localparam logic [3:0]  LastIdx     = 4'd11;
	localparam logic [7:0]  CrcPoly     = 8'h07;
	localparam logic [16:0] HumidMax    = 17'd100000;
	// order keys of -40.0f and 125.0f
	localparam logic [31:0] TempLowKey  = 32'h3DDF_FFFF;
	localparam logic [31:0] TempHighKey = 32'hC2FA_0000;

	typedef struct packed {
		logic        ok;
		logic [7:0]  sensor;
		logic [31:0] temp;
		logic [15:0] humid;
		logic [31:0] stamp;
		logic [7:0]  crc;
	} rec_t;

	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		c = crc ^ d;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] pkt_byte(input rec_t r, input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = r.sensor;
			4'd1:    b = r.temp[7:0];
			4'd2:    b = r.temp[15:8];
			4'd3:    b = r.temp[23:16];
			4'd4:    b = r.temp[31:24];
			4'd5:    b = r.humid[7:0];
			4'd6:    b = r.humid[15:8];
			4'd7:    b = r.stamp[7:0];
			4'd8:    b = r.stamp[15:8];
			4'd9:    b = r.stamp[23:16];
			4'd10:   b = r.stamp[31:24];
			4'd11:   b = r.crc;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: hw/rtl/spfc_check.sv
// First stage: unpack the input beat and validate the record.
module spfc_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [spfc_pkg::InWidth-1:0]      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output spfc_pkg::rec_t                    out_rec
);

	logic [15:0]     sensor;
	logic [31:0]     temp;
	logic [17:0]     humid;
	logic [31:0]     stamp;
	logic [31:0]     key;
	logic            is_nan;
	logic            temp_ok;
	logic            ok;
	logic            valid_s1;
	spfc_pkg::rec_t  rec_s1;

	assign sensor = in_data[15:0];
	assign temp   = in_data[47:16];
	assign humid  = in_data[65:48];
	assign stamp  = in_data[97:66];

	assign key     = temp[31] ? ~temp : (temp | 32'h8000_0000);
	assign is_nan  = (temp[30:23] == 8'hFF) && (temp[22:0] != 23'd0);
	assign temp_ok = is_nan || ((key >= spfc_pkg::TempLowKey) && (key <= spfc_pkg::TempHighKey));
	assign ok      = (sensor[15:8] == 8'd0) && temp_ok && !humid[17]
		&& (humid[16:0] <= spfc_pkg::HumidMax) && (stamp != 32'd0);

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rec_s1.ok     <= ok;
			rec_s1.sensor <= sensor[7:0];
			rec_s1.temp   <= temp;
			rec_s1.humid  <= humid[15:0];
			rec_s1.stamp  <= stamp;
			rec_s1.crc    <= 8'h00;
		end
	end

	assign out_valid = valid_s1;
	assign out_rec   = rec_s1;

endmodule

// File: hw/rtl/spfc_crc.sv
// CRC stage: folds a slice of the packet bytes into the running CRC.
module spfc_crc #(
	parameter int unsigned FIRST = 0,
	parameter int unsigned COUNT = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  spfc_pkg::rec_t in_rec,
	output logic           out_valid,
	input  logic           out_ready,
	output spfc_pkg::rec_t out_rec
);

	logic [7:0]     crc_next;
	spfc_pkg::rec_t rec_next;
	logic           valid_s;
	spfc_pkg::rec_t rec_s;

	always_comb begin
		crc_next = in_rec.crc;
		for (int k = 0; k < COUNT; k++) begin
			crc_next = spfc_pkg::crc_byte(crc_next, spfc_pkg::pkt_byte(in_rec, 4'(FIRST + k)));
		end
		rec_next     = in_rec;
		rec_next.crc = crc_next;
	end

	assign in_ready = !valid_s || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rec_s <= rec_next;
		end
	end

	assign out_valid = valid_s;
	assign out_rec   = rec_s;

endmodule

// File: hw/rtl/spfc_ser.sv
// Output serializer: emits a framed packet byte by byte, or one error beat.
`include "assert_macros.svh"

module spfc_ser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  spfc_pkg::rec_t in_rec,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           out_last,
	output logic           out_err
);

	logic           busy_q;
	logic [3:0]     cnt_q;
	spfc_pkg::rec_t hold_q;
	logic           beat_done;

	assign out_valid = busy_q;
	assign out_err   = !hold_q.ok;
	assign out_last  = !hold_q.ok || (cnt_q == spfc_pkg::LastIdx);
	assign out_byte  = hold_q.ok ? spfc_pkg::pkt_byte(hold_q, cnt_q) : 8'h00;
	assign beat_done = busy_q && out_ready;
	assign in_ready  = !busy_q || (beat_done && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else if (in_ready) begin
			busy_q <= in_valid;
			cnt_q  <= 4'd0;
		end else if (beat_done) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hold_q <= in_rec;
		end
	end

	`SPFC_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= spfc_pkg::LastIdx)
	`SPFC_ASSERT(a_err_single, clk, arst_n, (busy_q && !hold_q.ok) |-> (cnt_q == 4'd0))
	`SPFC_ASSERT(a_stall_hold, clk, arst_n, (busy_q && !out_ready) |=> (busy_q && $stable(cnt_q)))
	`SPFC_ASSERT(a_take_at_end, clk, arst_n, (busy_q && in_ready) |-> (out_ready && out_last))

endmodule

// File: hw/rtl/sensor_packet_framer_crc8.sv
// Top level of the sensor packet framer with CRC-8 trailer.
//
// channel  dir  beat                         fields (low bit up)
// s_*      in   one sensor record            tdata: sensor_number[15:0], temperature_bits[47:16],
//                                            humidity_milli[65:48], time_stamp[97:66], pad
// m_*      out  one packet byte              tdata: packet_byte; tlast: last_byte;
//                                            tuser: invalid_record
//
// A record runs through five register stages (validate, then four CRC slices) and
// is then serialized: 12 output beats for a valid record, one for an invalid one.
// The byte-wide output port sets the pace; the serializer takes the next record as
// its last beat is accepted, and the stages ahead of it can hold further records.
// The first byte reaches m_* through the validate, four CRC and serializer registers.
// arst_n clears all valid bits; stalls on m_tready back up through the stages
// without loss, and s_tready stays high while any stage has room.
module sensor_packet_framer_crc8 (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // sensor_number, temperature_bits, humidity_milli, time_stamp
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // packet_byte
	output logic         m_tlast,
	output logic [0:0]   m_tuser    // invalid_record
);

	logic           v1, v2, v3, v4, v5;
	logic           r1, r2, r3, r4, r5;
	spfc_pkg::rec_t rec1, rec2, rec3, rec4, rec5;

	spfc_check u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.out_valid(v1), .out_ready(r1), .out_rec(rec1)
	);

	spfc_crc #(.FIRST(0), .COUNT(3)) u_crc0 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v1), .in_ready(r1), .in_rec(rec1),
		.out_valid(v2), .out_ready(r2), .out_rec(rec2)
	);

	spfc_crc #(.FIRST(3), .COUNT(3)) u_crc1 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v2), .in_ready(r2), .in_rec(rec2),
		.out_valid(v3), .out_ready(r3), .out_rec(rec3)
	);

	spfc_crc #(.FIRST(6), .COUNT(3)) u_crc2 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v3), .in_ready(r3), .in_rec(rec3),
		.out_valid(v4), .out_ready(r4), .out_rec(rec4)
	);

	spfc_crc #(.FIRST(9), .COUNT(2)) u_crc3 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v4), .in_ready(r4), .in_rec(rec4),
		.out_valid(v5), .out_ready(r5), .out_rec(rec5)
	);

	spfc_ser u_ser (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v5), .in_ready(r5), .in_rec(rec5),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_byte(m_tdata), .out_last(m_tlast), .out_err(m_tuser[0])
	);

endmodule

// File: bench/testbench.sv
// Self-checking bench for the sensor packet framer: directed record table, then random records.
module testbench;

	localparam int            RESET_CYCLES   = 5;
	localparam int            NUM_DIRECTED   = 24;
	localparam int            RANDOM_RECORDS = 380;
	localparam int            IDLE_LIMIT     = 2000;
	localparam int            DRAIN_CYCLES   = 24;
	localparam int            MAX_REPORTS    = 10;
	localparam int            PACKET_BYTES   = 12;
	localparam int            SENSOR_LIMIT   = 255;
	localparam int            HUMID_LIMIT    = 100000;
	localparam logic [7:0]    CRC_POLY8      = 8'h07;
	localparam logic [31:0]   TEMP_MIN_BITS  = 32'hC220_0000;  // -40.0
	localparam logic [31:0]   TEMP_MAX_BITS  = 32'h42FA_0000;  // 125.0

	typedef enum logic { ROW_PREDICT, ROW_REJECT } row_verdict_e;
	typedef enum logic [1:0] { RX_STREAM, RX_COIN, RX_SPARSE, RX_STALLS } rx_mode_e;

	typedef struct packed {
		logic [31:0] stamp;
		logic [17:0] humid;
		logic [31:0] temp;
		logic [15:0] id;
	} sensor_rec_t;

	typedef struct packed {
		row_verdict_e verdict;
		logic [15:0]  id;
		logic [31:0]  temp;
		logic [17:0]  humid;
		logic [31:0]  stamp;
	} dir_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       invalid;
	} packet_beat_t;

	localparam packet_beat_t REJECT_BEAT = '{data: 8'h00, last: 1'b1, invalid: 1'b1};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;   // sensor_number, temperature_bits, humidity_milli, time_stamp, pad
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;   // packet_byte
	logic         m_tlast;
	logic [0:0]   m_tuser;   // invalid_record

	sensor_packet_framer_crc8 u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// predictor state
	logic [7:0]   held_sensor;
	logic [31:0]  held_temp;
	logic [15:0]  held_humid;
	logic [31:0]  held_stamp;
	logic [3:0]   bytes_sent;
	logic [7:0]   last_crc;

	packet_beat_t expected_beats [$];
	dir_row_t     directed_rows [NUM_DIRECTED];

	int records_sent;
	int packets_framed;
	int records_rejected;
	int beats_checked;
	int mismatches;
	int idle_cycles;

	rx_mode_e     rx_mode;
	int           rx_left;
	int           stall_left;
	packet_beat_t want_beat;
	packet_beat_t got_beat;

	function automatic logic [31:0] float_order(input logic [31:0] b);
		return b[31] ? ~b : (b | 32'h8000_0000);
	endfunction

	// ordered compare: NaN is never below or above, so it passes
	function automatic logic temp_accepted(input logic [31:0] b);
		if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
			return 1'b1;
		end
		return float_order(b) >= float_order(TEMP_MIN_BITS) &&
			float_order(b) <= float_order(TEMP_MAX_BITS);
	endfunction

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		c = crc ^ d;
		repeat (8) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY8) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic void frame_record(input sensor_rec_t r, input logic typed_reject);
		logic [7:0] pkt [PACKET_BYTES];
		logic [7:0] crc;
		logic       ok;
		ok = r.id <= SENSOR_LIMIT && temp_accepted(r.temp) && !r.humid[17] &&
			r.humid <= HUMID_LIMIT && r.stamp != 32'd0;
		if (typed_reject || !ok) begin
			bytes_sent = 4'd0;
			records_rejected++;
			expected_beats.push_back(REJECT_BEAT);
			return;
		end
		held_sensor = r.id[7:0];
		held_temp   = r.temp;
		held_humid  = r.humid[15:0];
		held_stamp  = r.stamp;
		pkt[0]  = held_sensor;
		pkt[1]  = held_temp[7:0];
		pkt[2]  = held_temp[15:8];
		pkt[3]  = held_temp[23:16];
		pkt[4]  = held_temp[31:24];
		pkt[5]  = held_humid[7:0];
		pkt[6]  = held_humid[15:8];
		pkt[7]  = held_stamp[7:0];
		pkt[8]  = held_stamp[15:8];
		pkt[9]  = held_stamp[23:16];
		pkt[10] = held_stamp[31:24];
		crc = 8'h00;
		for (int k = 0; k < PACKET_BYTES - 1; k++) begin
			crc = crc8_step(crc, pkt[k]);
		end
		pkt[11]  = crc;
		last_crc = crc;
		for (int k = 0; k < PACKET_BYTES; k++) begin
			expected_beats.push_back('{data: pkt[k], last: k == PACKET_BYTES - 1, invalid: 1'b0});
		end
		bytes_sent = 4'(PACKET_BYTES);
		packets_framed++;
	endfunction

	// mostly near or inside the window; exponents straddle both bounds
	function automatic logic [31:0] random_temp();
		logic sign;
		int   pick;
		sign = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			return {sign, 8'($urandom_range(0, sign ? 8'h84 : 8'h85)), 23'($urandom)};
		end else if (pick < 90) begin
			return {sign, 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
		end
		case ($urandom_range(0, 7))
			0:       return TEMP_MIN_BITS;
			1:       return TEMP_MAX_BITS;
			2:       return TEMP_MIN_BITS + 32'd1;
			3:       return TEMP_MAX_BITS + 32'd1;
			4:       return {sign, 31'd0};
			5:       return {sign, 8'hFF, 23'd0};
			6:       return TEMP_MAX_BITS - 32'd1;
			default: return TEMP_MIN_BITS - 32'd1;
		endcase
	endfunction

	function automatic sensor_rec_t random_record();
		sensor_rec_t r;
		int          pick;
		r.id    = 16'($urandom_range(0, SENSOR_LIMIT));
		r.temp  = random_temp();
		r.humid = 18'($urandom_range(0, HUMID_LIMIT));
		r.stamp = $urandom;
		if (r.stamp == 32'd0) begin
			r.stamp = 32'd1;
		end
		pick = $urandom_range(0, 99);
		if (pick >= 90) begin
			case ($urandom_range(0, 3))
				0:       r.id = 16'($urandom_range(SENSOR_LIMIT, SENSOR_LIMIT + 1));
				1:       r.humid = $urandom_range(0, 1) ?
						18'($urandom_range(HUMID_LIMIT - 1, HUMID_LIMIT + 1)) :
						18'($urandom_range(0, 1) ? 0 : -1);
				2:       r.temp = {1'($urandom_range(0, 1)), 8'hFF, 23'd0};
				default: r.stamp = 32'($urandom_range(0, 1));
			endcase
		end else if (pick >= 70) begin
			// noise: each field may be anything
			if ($urandom_range(0, 1)) r.id = 16'($urandom);
			if ($urandom_range(0, 1)) r.temp = $urandom;
			if ($urandom_range(0, 1)) r.humid = 18'($urandom);
			if ($urandom_range(0, 3) == 0) r.stamp = 32'd0;
			else if ($urandom_range(0, 1)) r.stamp = $urandom;
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input packet_beat_t want,
		input packet_beat_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("mismatch (%s) beat %0d: exp data=%02h last=%b inv=%b, got %02h %b %b",
				what, beats_checked, want.data, want.last, want.invalid,
				got.data, got.last, got.invalid);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: ready pattern switches among several modes
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 128);
		end
		rx_left--;
		case (rx_mode)
			RX_STREAM: m_tready = 1'b1;
			RX_COIN:   m_tready = 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready = (rx_left % 4) == 0;
			default: begin
				if (stall_left != 0) begin
					stall_left--;
					m_tready = 1'b0;
				end else begin
					m_tready = 1'b1;
					if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_beat = '{data: m_tdata, last: m_tlast, invalid: m_tuser[0]};
			if (expected_beats.size() == 0) begin
				flag_mismatch("unexpected beat", '0, got_beat);
			end else begin
				want_beat = expected_beats.pop_front();
				if (got_beat.data !== want_beat.data)
					flag_mismatch("packet_byte", want_beat, got_beat);
				else if (got_beat.last !== want_beat.last)
					flag_mismatch("last_byte", want_beat, got_beat);
				else if (got_beat.invalid !== want_beat.invalid)
					flag_mismatch("invalid_record", want_beat, got_beat);
			end
			beats_checked++;
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("timeout: no beat moved for %0d cycles, %0d beats still expected",
			IDLE_LIMIT, expected_beats.size());
		$display("** sensor_packet_framer_crc8: FAILED **");
		$finish;
	end

	initial begin
		sensor_rec_t rec;
		logic        typed_reject;
		int          burst_left;
		int          gap;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		held_sensor = '0;
		held_temp   = '0;
		held_humid  = '0;
		held_stamp  = '0;
		bytes_sent  = '0;
		last_crc    = '0;
		burst_left  = 0;

		//                verdict      id        temp          humidity   stamp
		directed_rows = '{
			'{ROW_PREDICT, 16'h0000, 32'h0000_0000, 18'h00000, 32'h0000_0001},
			'{ROW_PREDICT, 16'h00FF, 32'h8000_0000, 18'h186A0, 32'hFFFF_FFFF},
			'{ROW_REJECT,  16'h0100, 32'h3F80_0000, 18'h0C350, 32'h0000_0010},
			'{ROW_REJECT,  16'hFFFF, 32'h3F80_0000, 18'h0C350, 32'h0000_0010},
			'{ROW_PREDICT, 16'h0012, 32'hC220_0000, 18'h01234, 32'h1234_5678},
			'{ROW_REJECT,  16'h0012, 32'hC220_0001, 18'h01234, 32'h1234_5678},
			'{ROW_PREDICT, 16'h0034, 32'h42FA_0000, 18'h04321, 32'h8765_4321},
			'{ROW_REJECT,  16'h0034, 32'h42FA_0001, 18'h04321, 32'h8765_4321},
			'{ROW_REJECT,  16'h0056, 32'h7F80_0000, 18'h00100, 32'h0000_0100},
			'{ROW_REJECT,  16'h0056, 32'hFF80_0000, 18'h00100, 32'h0000_0100},
			'{ROW_PREDICT, 16'h0078, 32'h7FC0_0000, 18'h00200, 32'h0000_0200},
			'{ROW_PREDICT, 16'h0078, 32'h7F80_0001, 18'h00200, 32'h0000_0200},
			'{ROW_PREDICT, 16'h0078, 32'hFFFF_FFFF, 18'h00200, 32'h0000_0200},
			'{ROW_PREDICT, 16'h009A, 32'h0000_0001, 18'h00300, 32'h0000_0300},
			'{ROW_PREDICT, 16'h009A, 32'hC21F_FFFF, 18'h00300, 32'h0000_0300},
			'{ROW_REJECT,  16'h00BC, 32'h4120_0000, 18'h186A1, 32'h0000_0400},
			'{ROW_REJECT,  16'h00BC, 32'h4120_0000, 18'h3FFFF, 32'h0000_0400},
			'{ROW_REJECT,  16'h00BC, 32'h4120_0000, 18'h20000, 32'h0000_0400},
			'{ROW_REJECT,  16'h00BC, 32'h4120_0000, 18'h1FFFF, 32'h0000_0400},
			'{ROW_PREDICT, 16'h00DE, 32'h4120_0000, 18'h0FFFF, 32'h0000_0500},
			'{ROW_PREDICT, 16'h00DE, 32'h4120_0000, 18'h10000, 32'h0000_0500},
			'{ROW_REJECT,  16'h00DE, 32'h4120_0000, 18'h00500, 32'h0000_0000},
			'{ROW_REJECT,  16'hFFFF, 32'hFFFF_FFFF, 18'h3FFFF, 32'hFFFF_FFFF},
			'{ROW_PREDICT, 16'h00A5, 32'h41C8_0000, 18'h0C350, 32'h5A5A_5A5A}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int n = 0; n < NUM_DIRECTED + RANDOM_RECORDS; n++) begin
			if (n < NUM_DIRECTED) begin
				rec.id       = directed_rows[n].id;
				rec.temp     = directed_rows[n].temp;
				rec.humid    = directed_rows[n].humid;
				rec.stamp    = directed_rows[n].stamp;
				typed_reject = directed_rows[n].verdict == ROW_REJECT;
			end else begin
				rec          = random_record();
				typed_reject = 1'b0;
			end
			// sender bursts: random length, random gap, often none
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					s_tvalid = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
			s_tdata  = {6'b0, rec};
			s_tvalid = 1'b1;
			do @(posedge clk); while (!s_tready);
			frame_record(rec, typed_reject);
			records_sent++;
			@(negedge clk);
		end
		s_tvalid = 1'b0;

		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d records: %0d framed as packets, %0d rejected",
			records_sent, packets_framed, records_rejected);
		$display("checked %0d output beats, %0d mismatches", beats_checked, mismatches);
		if (mismatches == 0) begin
			$display("** sensor_packet_framer_crc8: PASSED **");
		end else begin
			$display("** sensor_packet_framer_crc8: FAILED **");
		end
		$finish;
	end

endmodule
